>>> rtl/local_mean_adaptive_threshold_top_assert.svh
// ----------------------------------------------------------------------------
// local mean adaptive threshold assertion macros
// concurrent checks clocked on clk_i, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef LOCAL_MEAN_ADAPTIVE_THRESHOLD_TOP_ASSERT_SVH
`define LOCAL_MEAN_ADAPTIVE_THRESHOLD_TOP_ASSERT_SVH

// check outside of reset
`define LMAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds while reset is active
`define LMAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lmat_pkg.sv
// ----------------------------------------------------------------------------
// lmat_pkg
// shared types and constants of the local mean adaptive threshold block
// ----------------------------------------------------------------------------
`default_nettype none

package lmat_pkg;

  localparam int MaxWidthDef  = 2048;
  localparam int MaxWindowDef = 15;
  localparam int HeightLimit  = 2048;

  localparam int RowW  = 12;
  localparam int RegW  = 12;
  localparam int WinW  = 4;
  localparam int OffW  = 13;
  localparam int CfgW  = 13;
  localparam int HalfW = 4;
  localparam int SumW  = 16;
  localparam int CntW  = 8;
  localparam int PixW  = 8;

  localparam logic [1:0] CfgImageWidth  = 2'd0;
  localparam logic [1:0] CfgImageHeight = 2'd1;
  localparam logic [1:0] CfgWindowSize  = 2'd2;
  localparam logic [1:0] CfgOffsetC     = 2'd3;

  localparam logic [RegW-1:0] WidthRst  = 12'd640;
  localparam logic [RegW-1:0] HeightRst = 12'd480;
  localparam logic [WinW-1:0] WindowRst = 4'd3;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            drain;
  } in_t;

  typedef struct packed {
    logic is_white;
    logic last_of_frame;
  } out_t;

  typedef struct packed {
    logic            vld;
    logic [SumW-1:0] sum;
    logic [CntW-1:0] n;
    logic [PixW-1:0] pix;
  } dec_req_t;

endpackage

`default_nettype wire

>>> rtl/lmat_store.sv
// ----------------------------------------------------------------------------
// lmat_store
// pixel line store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lmat_store #(
  parameter int Depth = 32768,
  parameter int Aw    = 15
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [Aw-1:0]           waddr_i,
  input  wire logic [lmat_pkg::PixW-1:0] wdata_i,
  input  wire logic [Aw-1:0]           raddr_i,
  output logic      [lmat_pkg::PixW-1:0] rdata_o
);
  import lmat_pkg::*;

  logic [PixW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/lmat_decide.sv
// ----------------------------------------------------------------------------
// lmat_decide
// two stage compare of pixel against rounded offset mean without division
// ----------------------------------------------------------------------------
`default_nettype none

module lmat_decide (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lmat_pkg::dec_req_t       req_i,
  input  wire logic signed [lmat_pkg::OffW-1:0] offset_i,
  output logic                          res_vld_o,
  output logic                          is_white_o
);
  import lmat_pkg::*;

  logic               v1_q;
  logic [16:0]        m1_q;
  logic signed [21:0] m2_q;
  logic [19:0]        s16_q;
  logic signed [22:0] lhs;
  logic signed [22:0] rhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      res_vld_o <= 1'b0;
    end else begin
      v1_q      <= req_i.vld;
      res_vld_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      m1_q  <= 17'(req_i.n) * 17'({req_i.pix, 1'b1});
      m2_q  <= 22'($signed({1'b0, req_i.n})) * 22'(offset_i);
      s16_q <= {req_i.sum, 4'b0};
    end
  end

  // white when 8n(2p+1) + n*k > 16*sum
  assign lhs = $signed({3'b0, m1_q, 3'b0}) + 23'(m2_q);
  assign rhs = $signed({3'b0, s16_q});

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      is_white_o <= (lhs > rhs);
    end
  end

endmodule

`default_nettype wire

>>> rtl/local_mean_adaptive_threshold_top.sv
// an item without a result passes the transfer (IDLE) and evaluate (EVAL) states;
// one with a result also scans the n in-frame pixels of its window (up to 225),
// one entry a cycle over the single read port of the line store, then PIX, PIXW, DEC, WOUT
// one item at a time: the input stalls outside IDLE, also while the output stalls
// reset: counters zero, registers 640/480/3/0, line store not cleared
// ----------------------------------------------------------------------------
// local_mean_adaptive_threshold_top
// raster pixel stream to binary image by local window mean threshold
// ----------------------------------------------------------------------------
`default_nettype none

module local_mean_adaptive_threshold_top #(
  parameter int MAX_WIDTH  = lmat_pkg::MaxWidthDef,
  parameter int MAX_WINDOW = lmat_pkg::MaxWindowDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [lmat_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire lmat_pkg::in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output lmat_pkg::out_t                 out_data_o
);
  import lmat_pkg::*;

  localparam int HalfLimit = MAX_WINDOW / 2;
  localparam int RingRows  = 2 * HalfLimit + 2;
  localparam int Rw        = $clog2(RingRows);
  localparam int Cw        = $clog2(MAX_WIDTH);
  localparam int Ww        = $clog2(MAX_WIDTH + 1) + 1;
  localparam int Depth     = RingRows * MAX_WIDTH;
  localparam int Aw        = $clog2(Depth);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_PIX  = 3'd3;
  localparam logic [2:0] ST_PIXW = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;
  localparam logic [2:0] ST_WOUT = 3'd6;

  logic [2:0] state_q, state_d;

  logic [RegW-1:0]        width_q;
  logic [RegW-1:0]        height_q;
  logic [WinW-1:0]        wsize_q;
  logic signed [OffW-1:0] offset_q;

  logic [Cw-1:0]   ic_q, ic_d, oc_q, oc_d;
  logic [RowW-1:0] ir_q, ir_d, or_q, or_d;
  logic [Rw-1:0]   iring_q, iring_d, oring_q, oring_d;

  logic [Rw-1:0]   yr_q, yr_d;
  logic [Cw-1:0]   x_q, x_d, c0_q, c0_d;
  logic [HalfW-1:0] yi_q, yi_d, xi_q, xi_d, ny_q, ny_d, nx_q, nx_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] n_q, n_d;
  logic [Aw-1:0]   pa_q, pa_d;
  logic            last_q, last_d;
  logic            rd_vld_q;
  logic            white_q, white_d;
  logic            out_vld_q, out_vld_d;
  out_t            out_q, out_d;

  logic [Ww-1:0]   w, wm1;
  logic [RowW-1:0] h, hm1;
  logic [WinW-1:0] side;
  logic [HalfW-1:0] half_raw, half;

  logic            accept, clr, wr;
  logic [Cw-1:0]   ic0;
  logic [RowW-1:0] ir0;
  logic [Rw-1:0]   iring0;
  logic [Ww-1:0]   icn, ocn, cc, c1t, c1, c0;
  logic [RowW:0]   r1t, r1;
  logic [RowW-1:0] r0, orn;
  logic            due;
  logic [HalfW-1:0] dy;
  logic [Aw-1:0]   waddr, raddr;
  logic [PixW-1:0] rdata;
  dec_req_t        req;
  logic            res_vld, res_white;

  // effective register values
  always_comb begin
    if (width_q == '0) begin
      w = Ww'(1);
    end else if (width_q > MAX_WIDTH) begin
      w = Ww'(MAX_WIDTH);
    end else begin
      w = Ww'(width_q);
    end
    wm1 = w - Ww'(1);
    if (height_q == '0) begin
      h = RowW'(1);
    end else if (height_q > HeightLimit) begin
      h = RowW'(HeightLimit);
    end else begin
      h = height_q;
    end
    hm1      = h - RowW'(1);
    side     = wsize_q[0] ? wsize_q : wsize_q + WinW'(1);
    half_raw = HalfW'(side >> 1);
    half     = (half_raw > HalfW'(HalfLimit)) ? HalfW'(HalfLimit) : half_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      wsize_q  <= WindowRst;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_data_i[RegW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[RegW-1:0];
        CfgWindowSize:  wsize_q  <= cfg_data_i[WinW-1:0];
        CfgOffsetC:     offset_q <= $signed(cfg_data_i[OffW-1:0]);
        default:        width_q  <= width_q;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // transfer side: frame restart after a height change, pixel write
  always_comb begin
    clr    = (or_q >= h);
    ic0    = clr ? '0 : ic_q;
    ir0    = clr ? '0 : ir_q;
    iring0 = clr ? '0 : iring_q;
    wr     = accept && !in_data_i.drain && (ir0 < h);
    waddr  = Aw'(iring0) * Aw'(MAX_WIDTH) + Aw'(ic0);
    icn    = Ww'(ic0) + Ww'(1);
  end

  // window bounds of the pending result
  always_comb begin
    cc  = (Ww'(oc_q) < w) ? Ww'(oc_q) : wm1;
    r1t = {1'b0, or_q} + (RowW+1)'(half);
    r1  = (r1t < {1'b0, hm1}) ? r1t : {1'b0, hm1};
    c1t = cc + Ww'(half);
    c1  = (c1t < wm1) ? c1t : wm1;
    r0  = (or_q > RowW'(half)) ? or_q - RowW'(half) : '0;
    c0  = (cc > Ww'(half)) ? cc - Ww'(half) : '0;
    due = ({1'b0, ir_q} > r1) || (({1'b0, ir_q} == r1) && (Ww'(ic_q) > c1));
    dy  = HalfW'(or_q - r0);
    ocn = Ww'(oc_q) + Ww'(1);
  end

  always_comb begin
    state_d   = state_q;
    ic_d      = ic_q;
    ir_d      = ir_q;
    iring_d   = iring_q;
    oc_d      = oc_q;
    or_d      = or_q;
    oring_d   = oring_q;
    yr_d      = yr_q;
    x_d       = x_q;
    c0_d      = c0_q;
    yi_d      = yi_q;
    xi_d      = xi_q;
    ny_d      = ny_q;
    nx_d      = nx_q;
    n_d       = n_q;
    pa_d      = pa_q;
    last_d    = last_q;
    white_d   = white_q;
    sum_d     = rd_vld_q ? sum_q + SumW'(rdata) : sum_q;
    raddr     = pa_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    orn       = or_q + RowW'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ic_d    = ic0;
          ir_d    = ir0;
          iring_d = iring0;
          if (clr) begin
            oc_d    = '0;
            or_d    = '0;
            oring_d = '0;
          end
          if (wr) begin
            if (icn >= w) begin
              ic_d    = '0;
              ir_d    = ir0 + RowW'(1);
              iring_d = (iring0 == Rw'(RingRows - 1)) ? '0 : iring0 + Rw'(1);
            end else begin
              ic_d = Cw'(icn);
            end
          end
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!due) begin
          state_d = ST_IDLE;
        end else begin
          ny_d  = HalfW'(r1 - {1'b0, r0});
          nx_d  = HalfW'(c1 - c0);
          n_d   = CntW'((CntW'(r1 - {1'b0, r0}) + CntW'(1)) * (CntW'(c1 - c0) + CntW'(1)));
          yr_d  = (oring_q >= Rw'(dy)) ? oring_q - Rw'(dy)
                                       : oring_q + Rw'(RingRows) - Rw'(dy);
          c0_d  = Cw'(c0);
          x_d   = Cw'(c0);
          yi_d  = '0;
          xi_d  = '0;
          sum_d = '0;
          pa_d  = Aw'(oring_q) * Aw'(MAX_WIDTH) + Aw'(oc_q);
          if (ocn >= w) begin
            oc_d    = '0;
            or_d    = orn;
            oring_d = (oring_q == Rw'(RingRows - 1)) ? '0 : oring_q + Rw'(1);
            last_d  = (orn >= h);
          end else begin
            oc_d   = Cw'(ocn);
            last_d = 1'b0;
          end
          if ((ocn >= w) && (orn >= h)) begin
            ic_d    = '0;
            ir_d    = '0;
            iring_d = '0;
            oc_d    = '0;
            or_d    = '0;
            oring_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        raddr = Aw'(yr_q) * Aw'(MAX_WIDTH) + Aw'(x_q);
        if (xi_q == nx_q) begin
          xi_d = '0;
          x_d  = c0_q;
          yi_d = yi_q + HalfW'(1);
          yr_d = (yr_q == Rw'(RingRows - 1)) ? '0 : yr_q + Rw'(1);
          if (yi_q == ny_q) begin
            state_d = ST_PIX;
          end
        end else begin
          xi_d = xi_q + HalfW'(1);
          x_d  = x_q + Cw'(1);
        end
      end
      ST_PIX: begin
        raddr   = pa_q;
        state_d = ST_PIXW;
      end
      ST_PIXW: begin
        state_d = ST_DEC;
      end
      ST_DEC: begin
        if (res_vld) begin
          white_d = res_white;
          state_d = ST_WOUT;
        end
      end
      ST_WOUT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d           = 1'b1;
          out_d.is_white      = white_q;
          out_d.last_of_frame = last_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ic_q      <= '0;
      ir_q      <= '0;
      iring_q   <= '0;
      oc_q      <= '0;
      or_q      <= '0;
      oring_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ic_q      <= ic_d;
      ir_q      <= ir_d;
      iring_q   <= iring_d;
      oc_q      <= oc_d;
      or_q      <= or_d;
      oring_q   <= oring_d;
      rd_vld_q  <= (state_q == ST_SCAN);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    yr_q    <= yr_d;
    x_q     <= x_d;
    c0_q    <= c0_d;
    yi_q    <= yi_d;
    xi_q    <= xi_d;
    ny_q    <= ny_d;
    nx_q    <= nx_d;
    n_q     <= n_d;
    sum_q   <= sum_d;
    pa_q    <= pa_d;
    last_q  <= last_d;
    white_q <= white_d;
    out_q   <= out_d;
  end

  lmat_store #(
    .Depth (Depth),
    .Aw    (Aw)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (waddr),
    .wdata_i (in_data_i.pixel_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    req.vld = (state_q == ST_PIXW);
    req.sum = sum_q;
    req.n   = n_q;
    req.pix = rdata;
  end

  lmat_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .offset_i   (offset_q),
    .res_vld_o  (res_vld),
    .is_white_o (res_white)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`include "local_mean_adaptive_threshold_top_assert.svh"

  `LMAT_ASSERT(a_scan_exit, (state_q == ST_SCAN) |=> (state_q == ST_SCAN) || (state_q == ST_PIX), "scan left early")
  `LMAT_ASSERT(a_rd_from_scan, rd_vld_q |-> ($past(state_q) == ST_SCAN), "stray window read")
  `LMAT_ASSERT(a_dec_from_pixw, res_vld |-> (state_q == ST_DEC), "decision outside wait")
  `LMAT_ASSERT_RST(a_reset_idle, !rst_ni |-> (state_q == ST_IDLE) && !out_valid_o, "not idle in reset")

endmodule

`default_nettype wire
